// ----- rtl/vtyp_pkg.sv -----
// Shared constants, record types and the CORDIC arc table for the vector to
// yaw/pitch converter. No dependencies; every module of the block imports it.
package vtyp_pkg;

  // Input component width and number of CORDIC micro-rotations.
  localparam int COMPONENT_WIDTH   = 24;
  localparam int CORDIC_ITERATIONS = 16;

  // Stream payload widths.
  localparam int IN_DATA_W   = ((3 * COMPONENT_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 16;
  localparam int OUT_DATA_W  = 2 * OUT_FIELD_W;

  // Normalized magnitudes lie in (2^30, 2^31], so they need 32 bits.
  localparam int MAG_W    = 32;
  localparam int NORM_TOP = MAG_W - 1;
  localparam int SH_W     = 5;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int ROOT_W   = MAG_W;

  // CORDIC datapath: vector lanes carry the gain growth, angles are in
  // units of 2^-16 degree.
  localparam int XY_W      = 35;
  localparam int ANG_W     = 26;
  localparam int IDX_W     = 5;
  localparam int DEG_UNIT  = 65536;
  localparam int RND_SHIFT = 9;

  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180 * DEG_UNIT);
  localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(360 * DEG_UNIT);
  localparam logic signed [ANG_W-1:0] RND_HALF  = ANG_W'(1 << (RND_SHIFT - 1));

  // Output angles in 1/128 degree.
  localparam logic [OUT_FIELD_W-1:0] OUT_FULL = OUT_FIELD_W'(46080);
  localparam logic [OUT_FIELD_W-1:0] OUT_270  = OUT_FIELD_W'(34560);
  localparam logic [OUT_FIELD_W-1:0] OUT_90   = OUT_FIELD_W'(11520);
  localparam logic [OUT_FIELD_W-1:0] OUT_ZERO = '0;

  typedef struct packed {
    logic spec;   // x and y both zero
    logic z_pos;
    logic x_neg;
    logic y_neg;
    logic z_neg;
  } flags_t;

  typedef struct packed {
    flags_t           flg;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] az;
  } norm_t;

  typedef struct packed {
    flags_t                  flg;
    logic signed [XY_W-1:0]  yaw_px;
    logic signed [XY_W-1:0]  yaw_py;
    logic signed [XY_W-1:0]  pit_py;
  } side_t;

  typedef struct packed {
    logic spec;
    logic z_pos;
  } tag_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  px;
    logic signed [XY_W-1:0]  py;
    logic signed [ANG_W-1:0] acc;
  } lane_t;

  typedef struct packed {
    tag_t                    tag;
    logic signed [ANG_W-1:0] yaw;
    logic signed [ANG_W-1:0] pitch;
  } ang_t;

  // atan(2^-i) in units of 2^-16 degree.
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] r;
    case (idx)
      5'd0:    r = ANG_W'(2949120);
      5'd1:    r = ANG_W'(1740967);
      5'd2:    r = ANG_W'(919879);
      5'd3:    r = ANG_W'(466945);
      5'd4:    r = ANG_W'(234379);
      5'd5:    r = ANG_W'(117304);
      5'd6:    r = ANG_W'(58666);
      5'd7:    r = ANG_W'(29335);
      5'd8:    r = ANG_W'(14668);
      5'd9:    r = ANG_W'(7334);
      5'd10:   r = ANG_W'(3667);
      5'd11:   r = ANG_W'(1833);
      5'd12:   r = ANG_W'(917);
      5'd13:   r = ANG_W'(458);
      5'd14:   r = ANG_W'(229);
      5'd15:   r = ANG_W'(115);
      5'd16:   r = ANG_W'(57);
      5'd17:   r = ANG_W'(29);
      5'd18:   r = ANG_W'(14);
      5'd19:   r = ANG_W'(7);
      5'd20:   r = ANG_W'(4);
      5'd21:   r = ANG_W'(2);
      5'd22:   r = ANG_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/vtyp_norm.sv -----
// Four-stage normalizer: magnitudes, common power-of-two scale search and
// the left shift that brings the largest magnitude into (2^30, 2^31]. Uses vtyp_pkg.
module vtyp_norm import vtyp_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [COMPONENT_WIDTH-1:0] vec_x,
  input  logic signed [COMPONENT_WIDTH-1:0] vec_y,
  input  logic signed [COMPONENT_WIDTH-1:0] vec_z,
  output logic                              out_valid,
  output norm_t                             out_data
);

  localparam int CW = COMPONENT_WIDTH;

  // |a| - 1, or zero for a zero magnitude; fits one bit less than a.
  function automatic logic [CW-2:0] dec_mag(input logic [CW-1:0] a);
    logic [CW-1:0] d;
    d = (a == '0) ? '0 : a - CW'(1);
    return d[CW-2:0];
  endfunction

  logic [CW-1:0] xu, yu, zu;
  logic [CW-1:0] ax1_nxt, ay1_nxt, az1_nxt;
  flags_t        flg1_nxt;
  logic [CW-2:0] orv2_nxt;
  logic [SH_W-1:0] blen, sh3_nxt;
  norm_t         nd4_nxt;

  logic          v1_r, v2_r, v3_r, v4_r;
  logic [CW-1:0] ax1_r, ay1_r, az1_r, ax2_r, ay2_r, az2_r, ax3_r, ay3_r, az3_r;
  flags_t        flg1_r, flg2_r, flg3_r;
  logic [CW-2:0] orv2_r;
  logic [SH_W-1:0] sh3_r;
  norm_t         nd4_r;

  assign xu = vec_x;
  assign yu = vec_y;
  assign zu = vec_z;

  // Stage 1: magnitudes and sign flags.
  always_comb begin
    ax1_nxt        = xu[CW-1] ? (~xu + CW'(1)) : xu;
    ay1_nxt        = yu[CW-1] ? (~yu + CW'(1)) : yu;
    az1_nxt        = zu[CW-1] ? (~zu + CW'(1)) : zu;
    flg1_nxt.spec  = (xu == '0) && (yu == '0);
    flg1_nxt.z_pos = !zu[CW-1] && (zu != '0);
    flg1_nxt.x_neg = xu[CW-1];
    flg1_nxt.y_neg = yu[CW-1];
    flg1_nxt.z_neg = zu[CW-1];
  end

  // Stage 2: the bit length of the OR of (|v| - 1) equals ceil(log2(max |v|)).
  assign orv2_nxt = dec_mag(ax1_r) | dec_mag(ay1_r) | dec_mag(az1_r);

  // Stage 3: bit length to shift count.
  always_comb begin
    blen = '0;
    for (int i = 0; i < CW - 1; i++) begin
      if (orv2_r[i]) begin
        blen = SH_W'(i + 1);
      end
    end
    sh3_nxt = SH_W'(NORM_TOP) - blen;
  end

  // Stage 4: scale the magnitudes.
  always_comb begin
    nd4_nxt.flg = flg3_r;
    nd4_nxt.ax  = MAG_W'(ax3_r) << sh3_r;
    nd4_nxt.ay  = MAG_W'(ay3_r) << sh3_r;
    nd4_nxt.az  = MAG_W'(az3_r) << sh3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r  <= ax1_nxt;
      ay1_r  <= ay1_nxt;
      az1_r  <= az1_nxt;
      flg1_r <= flg1_nxt;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      az2_r  <= az1_r;
      flg2_r <= flg1_r;
      orv2_r <= orv2_nxt;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
      az3_r  <= az2_r;
      flg3_r <= flg2_r;
      sh3_r  <= sh3_nxt;
      nd4_r  <= nd4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = nd4_r;

endmodule

// ----- rtl/vtyp_sqrt.sv -----
// Horizontal length: squares, sum and a pipelined digit-by-digit integer
// square root, one result bit per stage. Also prepares the CORDIC lane inputs. Uses vtyp_pkg.
module vtyp_sqrt import vtyp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  norm_t             in_data,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  logic [SQ_W-1:0]        sqx_nxt, sqy_nxt, sqx_r, sqy_r, sum_r;
  side_t                  side_nxt, q1_side_r, q2_side_r;
  logic                   q1_v_r, q2_v_r;
  logic signed [XY_W-1:0] yabs, zabs;

  logic [SQ_W-1:0]   rem_c    [ROOT_W];
  logic [SQ_W-1:0]   rem_nxt  [ROOT_W-1];
  logic [SQ_W-1:0]   rem_r    [ROOT_W-1];
  logic [ROOT_W-1:0] root_c   [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];
  logic [ROOT_W-1:0] root_r   [ROOT_W];
  side_t             side_c   [ROOT_W];
  side_t             side_r   [ROOT_W];
  logic              v_c      [ROOT_W];
  logic              v_r      [ROOT_W];

  // Stage Q1: squares, and the lane inputs of both angle units.
  always_comb begin
    sqx_nxt         = SQ_W'(in_data.ax) * SQ_W'(in_data.ax);
    sqy_nxt         = SQ_W'(in_data.ay) * SQ_W'(in_data.ay);
    yabs            = $signed(XY_W'(in_data.ay));
    zabs            = $signed(XY_W'(in_data.az));
    side_nxt.flg    = in_data.flg;
    side_nxt.yaw_px = $signed(XY_W'(in_data.ax));
    side_nxt.yaw_py = (in_data.flg.x_neg ^ in_data.flg.y_neg) ? -yabs : yabs;
    side_nxt.pit_py = in_data.flg.z_neg ? zabs : -zabs;
  end

  // Root stages: stage j decides result bit ROOT_W-1-j.
  for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
    localparam int K = ROOT_W - 1 - j;
    logic [SQ_W+1:0] trial, diff;
    logic            take;

    if (j == 0) begin : g_first
      assign rem_c[j]  = sum_r;
      assign root_c[j] = '0;
      assign side_c[j] = q2_side_r;
      assign v_c[j]    = q2_v_r;
    end else begin : g_next
      assign rem_c[j]  = rem_r[j-1];
      assign root_c[j] = root_r[j-1];
      assign side_c[j] = side_r[j-1];
      assign v_c[j]    = v_r[j-1];
    end

    // The partial root has only bits above K, so the trial term is an OR.
    assign trial       = ((SQ_W+2)'(root_c[j]) << (K + 1)) | ((SQ_W+2)'(1) << (2 * K));
    assign diff        = (SQ_W+2)'(rem_c[j]) - trial;
    assign take        = ~diff[SQ_W+1];
    assign root_nxt[j] = take ? (root_c[j] | (ROOT_W'(1) << K)) : root_c[j];

    if (j < ROOT_W - 1) begin : g_rem
      assign rem_nxt[j] = take ? diff[SQ_W-1:0] : rem_c[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r <= 1'b0;
      q2_v_r <= 1'b0;
      for (int j = 0; j < ROOT_W; j++) begin
        v_r[j] <= 1'b0;
      end
    end else if (en) begin
      q1_v_r <= in_valid;
      q2_v_r <= q1_v_r;
      for (int j = 0; j < ROOT_W; j++) begin
        v_r[j] <= v_c[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r     <= sqx_nxt;
      sqy_r     <= sqy_nxt;
      q1_side_r <= side_nxt;
      sum_r     <= sqx_r + sqy_r;
      q2_side_r <= q1_side_r;
      for (int j = 0; j < ROOT_W; j++) begin
        root_r[j] <= root_nxt[j];
        side_r[j] <= side_c[j];
      end
      for (int j = 0; j < ROOT_W - 1; j++) begin
        rem_r[j] <= rem_nxt[j];
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

// ----- rtl/vtyp_cordic.sv -----
// Dual-lane pipelined CORDIC vectoring, one micro-rotation per stage, for
// yaw and pitch in lockstep. Uses vtyp_pkg.
module vtyp_cordic import vtyp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_root,
  input  side_t             in_side,
  output logic              out_valid,
  output ang_t              out_ang
);

  localparam int N = CORDIC_ITERATIONS;

  // Clockwise when y is zero or positive; shifts are arithmetic.
  function automatic lane_t micro_rot(input lane_t a, input int unsigned sh);
    lane_t                   r;
    logic signed [XY_W-1:0]  dx, dy;
    logic signed [ANG_W-1:0] da;
    dx = a.py >>> sh;
    dy = a.px >>> sh;
    da = atan_lut(IDX_W'(sh));
    if (!a.py[XY_W-1]) begin
      r.px  = a.px + dx;
      r.py  = a.py - dy;
      r.acc = a.acc + da;
    end else begin
      r.px  = a.px - dx;
      r.py  = a.py + dy;
      r.acc = a.acc - da;
    end
    return r;
  endfunction

  lane_t ent_yaw, ent_pit;
  tag_t  ent_tag;

  lane_t yaw_c [N];
  lane_t yaw_r [N];
  lane_t pit_c [N];
  lane_t pit_r [N];
  tag_t  tag_c [N];
  tag_t  tag_r [N];
  logic  v_c   [N];
  logic  v_r   [N];

  // Yaw of a vector with negative x starts from a half turn.
  always_comb begin
    ent_yaw.px    = in_side.yaw_px;
    ent_yaw.py    = in_side.yaw_py;
    ent_yaw.acc   = in_side.flg.x_neg ? HALF_TURN : '0;
    ent_pit.px    = $signed(XY_W'(in_root));
    ent_pit.py    = in_side.pit_py;
    ent_pit.acc   = '0;
    ent_tag.spec  = in_side.flg.spec;
    ent_tag.z_pos = in_side.flg.z_pos;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign yaw_c[i] = ent_yaw;
      assign pit_c[i] = ent_pit;
      assign tag_c[i] = ent_tag;
      assign v_c[i]   = in_valid;
    end else begin : g_next
      assign yaw_c[i] = yaw_r[i-1];
      assign pit_c[i] = pit_r[i-1];
      assign tag_c[i] = tag_r[i-1];
      assign v_c[i]   = v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < N; i++) begin
        v_r[i] <= v_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        yaw_r[i] <= micro_rot(yaw_c[i], i);
        pit_r[i] <= micro_rot(pit_c[i], i);
        tag_r[i] <= tag_c[i];
      end
    end
  end

  assign out_valid     = v_r[N-1];
  assign out_ang.tag   = tag_r[N-1];
  assign out_ang.yaw   = yaw_r[N-1].acc;
  assign out_ang.pitch = pit_r[N-1].acc;

endmodule

// ----- rtl/vector_to_yaw_pitch_unit.sv -----
// Top level of the vector to yaw/pitch converter: normalizer, root
// extractor, dual CORDIC, angle conversion and output skid. Uses vtyp_pkg
// and the vtyp_norm, vtyp_sqrt and vtyp_cordic modules.
//
// Channel | Direction | Payload (low bits first)
// --------+-----------+----------------------------------------------
// in_     | slave     | in_tdata: vec_x, vec_y, vec_z (signed)
// out_    | master    | out_tdata: pitch_angle, yaw_angle (1/128 deg)
//
// One request enters per clock while in_tready is high. It passes 56 register stages (four
// normalizer, two for the squares and their sum, 32 root, CORDIC_ITERATIONS rotations,
// conversion, output), the first loaded at the accepting edge; most of them are root stages.
// Reset clears every valid bit, those of the output and skid included; data is not reset.
// A low out_tready parks one more request in the skid register; the pipeline then freezes
// and in_tready drops until the skid entry moves up, so nothing is lost or repeated.
module vector_to_yaw_pitch_unit import vtyp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // vec_x, vec_y, vec_z
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // pitch_angle, yaw_angle
);

  localparam int CW = COMPONENT_WIDTH;

  // Wrap a negative angle by a full turn, round half up to 1/128 degree
  // and fold a full turn back to zero.
  function automatic logic [OUT_FIELD_W-1:0] to_deg_out(input logic signed [ANG_W-1:0] th);
    logic [ANG_W-1:0]       t;
    logic [OUT_FIELD_W-1:0] q;
    t = th[ANG_W-1] ? ANG_W'(th + FULL_TURN + RND_HALF) : ANG_W'(th + RND_HALF);
    q = OUT_FIELD_W'(t >> RND_SHIFT);
    if (q >= OUT_FULL) begin
      q = q - OUT_FULL;
    end
    return q;
  endfunction

  // Pipeline advance: everything moves unless the skid register is full.
  logic pipe_en;

  logic              norm_v, sqrt_v, cord_v;
  norm_t             norm_d;
  logic [ROOT_W-1:0] sqrt_root;
  side_t             sqrt_side;
  ang_t              cord_ang;

  logic                   conv_v_r;
  logic [OUT_FIELD_W-1:0] conv_pitch_nxt, conv_yaw_nxt, conv_pitch_r, conv_yaw_r;
  logic                   out_v_r, skid_v_r;
  logic [OUT_FIELD_W-1:0] out_pitch_r, out_yaw_r, skid_pitch_r, skid_yaw_r;

  assign pipe_en   = !skid_v_r;
  assign in_tready = pipe_en;

  vtyp_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_tvalid),
    .vec_x     ($signed(in_tdata[CW-1:0])),
    .vec_y     ($signed(in_tdata[2*CW-1:CW])),
    .vec_z     ($signed(in_tdata[3*CW-1:2*CW])),
    .out_valid (norm_v),
    .out_data  (norm_d)
  );

  vtyp_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (norm_v),
    .in_data   (norm_d),
    .out_valid (sqrt_v),
    .out_root  (sqrt_root),
    .out_side  (sqrt_side)
  );

  vtyp_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (sqrt_v),
    .in_root   (sqrt_root),
    .in_side   (sqrt_side),
    .out_valid (cord_v),
    .out_ang   (cord_ang)
  );

  // Conversion stage. With x and y both zero the angles are fixed: yaw is
  // zero, pitch points straight down for positive z and up otherwise.
  always_comb begin
    if (cord_ang.tag.spec) begin
      conv_pitch_nxt = cord_ang.tag.z_pos ? OUT_270 : OUT_90;
      conv_yaw_nxt   = OUT_ZERO;
    end else begin
      conv_pitch_nxt = to_deg_out(cord_ang.pitch);
      conv_yaw_nxt   = to_deg_out(cord_ang.yaw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_v_r <= 1'b0;
    end else if (pipe_en) begin
      conv_v_r <= cord_v;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      conv_pitch_r <= conv_pitch_nxt;
      conv_yaw_r   <= conv_yaw_nxt;
    end
  end

  // Output register with a one-entry skid behind it. A stalled output
  // parks the request leaving the conversion stage in the skid register;
  // once the output is taken, the skid entry moves up first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_tready) begin
      if (pipe_en && conv_v_r) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= pipe_en && conv_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_tready) begin
      if (pipe_en && conv_v_r) begin
        skid_pitch_r <= conv_pitch_r;
        skid_yaw_r   <= conv_yaw_r;
      end
    end else if (skid_v_r) begin
      out_pitch_r <= skid_pitch_r;
      out_yaw_r   <= skid_yaw_r;
    end else begin
      out_pitch_r <= conv_pitch_r;
      out_yaw_r   <= conv_yaw_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_yaw_r, out_pitch_r};

  // The skid register only fills behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without a waiting output");

  // A drained skid entry lands in the output register.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_tready) |=> (out_v_r && !skid_v_r))
    else $error("skid entry lost on drain");

  // Converted angles never reach a full turn.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_pitch_r < OUT_FULL) && (out_yaw_r < OUT_FULL)))
    else $error("output angle out of range");

  // A frozen pipeline keeps its last stage.
  a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (conv_v_r && !pipe_en) |=> conv_v_r)
    else $error("conversion stage dropped a request during a stall");

endmodule
